// ----- rtl/core/mf5_pkg.sv -----
// Shared types and constants of the 5x5 line median filter.
package mf5_pkg;

	// Window geometry and median position.
	localparam int WIN_N       = 5;
	localparam int WIN_SIZE    = WIN_N * WIN_N;
	localparam int MEDIAN_RANK = 12;
	localparam int RANK_W      = $clog2(WIN_SIZE);

	// Line geometry.
	localparam int MAX_WIDTH = 4096;
	localparam int MIN_WIDTH = 5;
	localparam int CNT_W     = $clog2(MAX_WIDTH);
	localparam int LW_W      = 13;
	localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

	// Result count of one input column.
	localparam int OUT_N  = 3;
	localparam int OCNT_W = 2;

	typedef logic [7:0] pix_t;

	// What one accepted column produces.
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_PASS     = 2'd1,
		KIND_MED      = 2'd2,
		KIND_MED_LAST = 2'd3
	} kind_t;

endpackage

// ----- rtl/core/mf5_in_if.sv -----
// Input channel: one column of five pixels per request.
interface mf5_in_if
	import mf5_pkg::*;
;
	logic valid;
	logic ready;
	pix_t row_top2;
	pix_t row_top1;
	pix_t row_center;
	pix_t row_bottom1;
	pix_t row_bottom2;

	modport source (
		output valid, row_top2, row_top1, row_center, row_bottom1, row_bottom2,
		input  ready
	);
	modport sink (
		input  valid, row_top2, row_top1, row_center, row_bottom1, row_bottom2,
		output ready
	);
endinterface

// ----- rtl/core/mf5_out_if.sv -----
// Output channel: one filtered pixel per request.
interface mf5_out_if
	import mf5_pkg::*;
;
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic run_last;

	modport source (
		output valid, pixel_out, run_last,
		input  ready
	);
	modport sink (
		input  valid, pixel_out, run_last,
		output ready
	);
endinterface

// ----- rtl/core/median_filter_5x5_line_core.sv -----
// 5x5 line median filter: window, column counter, median network and output buffer.
//
// Usage:
//   col_in carries one column of five pixels per request, top row first.
//   pix_out carries the filtered centre-row pixels in column order; run_last
//   marks the last pixel that one column causes. Columns 0 and 1 pass their
//   centre pixel, columns 2 and 3 give nothing, later columns give the median
//   of the last five columns, and the last column of a line also gives the
//   centre pixels of the last two columns.
//   line_width is written through the APB port at byte address 0 while idle;
//   it is clamped to 5..4096 and read anew for every column.
// Flow:
//   An accepted column goes into the window registers, and its results then
//   pass into the output buffer that drives pix_out. One column is taken every
//   cycle while the receiver keeps up; the last column of a line loads three
//   results into the buffer, so the input waits there while they drain. The
//   rank-select median network between the window registers and the output
//   buffer sets the clock period.
// Reset clears the window, the column count and the buffer and sets line_width
// to 640. When the receiver stalls with results pending, the buffer holds; once
// the window stage is also occupied, it holds too and col_in.ready drops.
module median_filter_5x5_line_core
	import mf5_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mf5_in_if.sink            col_in,
	mf5_out_if.source         pix_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [LW_W-1:0]  line_width_q;
	logic [CNT_W-1:0] column_count_q;
	pix_t             window_q [WIN_N][WIN_N];
	logic             valid_s1;
	kind_t            kind_s1;
	pix_t             res_q [OUT_N];
	logic [OCNT_W-1:0] cnt_q;

	logic             in_acc;
	logic             out_take;
	logic             out_free;
	logic             adv_s1;
	logic [LW_W-1:0]  eff_width;
	logic [LW_W-1:0]  next_count;
	logic             last_col;
	kind_t            kind_in;
	pix_t             new_col [WIN_N];
	pix_t             med;

	// Configuration register and read-back.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_WIDTH) begin
			line_width_q <= pwdata[LW_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LINE_WIDTH) begin
			prdata = APB_DW'(line_width_q);
		end
	end

	// Handshakes. The buffer can take a new column's results when it is empty
	// or its final pending result leaves in this cycle.
	assign out_take = pix_out.valid && pix_out.ready;
	assign out_free = (cnt_q == '0) || (cnt_q == OCNT_W'(1) && pix_out.ready);
	assign adv_s1   = valid_s1 && out_free;
	assign col_in.ready = !valid_s1 || out_free;
	assign in_acc   = col_in.valid && col_in.ready;

	// Effective width, end of line and the kind of this column.
	always_comb begin
		eff_width = line_width_q;
		if (line_width_q < LW_W'(MIN_WIDTH)) begin
			eff_width = LW_W'(MIN_WIDTH);
		end else if (line_width_q > LW_W'(MAX_WIDTH)) begin
			eff_width = LW_W'(MAX_WIDTH);
		end
		next_count = {1'b0, column_count_q} + LW_W'(1);
		last_col   = next_count >= eff_width;
		if (column_count_q < CNT_W'(2)) begin
			kind_in = KIND_PASS;
		end else if (column_count_q < CNT_W'(4)) begin
			kind_in = KIND_NONE;
		end else if (last_col) begin
			kind_in = KIND_MED_LAST;
		end else begin
			kind_in = KIND_MED;
		end
	end

	assign new_col[0] = col_in.row_top2;
	assign new_col[1] = col_in.row_top1;
	assign new_col[2] = col_in.row_center;
	assign new_col[3] = col_in.row_bottom1;
	assign new_col[4] = col_in.row_bottom2;

	// Window shift, column count and the window stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN_N; r++) begin
				for (int c = 0; c < WIN_N; c++) begin
					window_q[r][c] <= '0;
				end
			end
			column_count_q <= '0;
			valid_s1       <= 1'b0;
			kind_s1        <= KIND_NONE;
		end else begin
			if (in_acc) begin
				for (int r = 0; r < WIN_N; r++) begin
					for (int c = 0; c < WIN_N - 1; c++) begin
						window_q[r][c] <= window_q[r][c+1];
					end
					window_q[r][WIN_N-1] <= new_col[r];
				end
				column_count_q <= last_col ? '0 : next_count[CNT_W-1:0];
				kind_s1        <= kind_in;
				valid_s1       <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Median by rank: each pixel counts the pixels that sort before it, with
	// ties broken by position, and the one of rank twelve is picked.
	always_comb begin
		pix_t                v   [WIN_SIZE];
		logic                le  [WIN_SIZE][WIN_SIZE];
		logic [WIN_SIZE-1:0] bef [WIN_SIZE];
		logic [RANK_W-1:0]   rank;
		for (int r = 0; r < WIN_N; r++) begin
			for (int c = 0; c < WIN_N; c++) begin
				v[r*WIN_N + c] = window_q[r][c];
			end
		end
		for (int i = 0; i < WIN_SIZE; i++) begin
			for (int j = 0; j < WIN_SIZE; j++) begin
				le[i][j] = (i < j) ? (v[i] <= v[j]) : 1'b0;
			end
		end
		med = '0;
		for (int i = 0; i < WIN_SIZE; i++) begin
			for (int j = 0; j < WIN_SIZE; j++) begin
				if (j < i) begin
					bef[i][j] = le[j][i];
				end else if (j > i) begin
					bef[i][j] = !le[i][j];
				end else begin
					bef[i][j] = 1'b0;
				end
			end
			rank = RANK_W'($countones(bef[i]));
			if (rank == RANK_W'(MEDIAN_RANK)) begin
				med = med | v[i];
			end
		end
	end

	// Output buffer: results leave from the head, the count says how many remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv_s1) begin
			case (kind_s1)
				KIND_PASS:     cnt_q <= OCNT_W'(1);
				KIND_MED:      cnt_q <= OCNT_W'(1);
				KIND_MED_LAST: cnt_q <= OCNT_W'(3);
				default:       cnt_q <= '0;
			endcase
		end else if (out_take) begin
			cnt_q <= cnt_q - OCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q[0] <= (kind_s1 == KIND_PASS) ? window_q[2][WIN_N-1] : med;
			res_q[1] <= window_q[2][WIN_N-2];
			res_q[2] <= window_q[2][WIN_N-1];
		end else if (out_take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign pix_out.valid     = cnt_q != '0;
	assign pix_out.pixel_out = res_q[0];
	assign pix_out.run_last  = cnt_q == OCNT_W'(1);

	// A column is never taken while the buffer still holds two or more results
	// and the window stage is occupied.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(valid_s1 && cnt_q > OCNT_W'(1)))
		else $error("column accepted while results are still pending");

	// The end of a line restarts the column count.
	a_line_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col |=> column_count_q == '0)
		else $error("column count did not wrap at end of line");

	// The last column of a line loads three results.
	a_last_three: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && kind_s1 == KIND_MED_LAST |=> cnt_q == OCNT_W'(3))
		else $error("end of line did not load three results");

endmodule

// ----- sim/tb_median_filter_5x5_line_core.sv -----
// Testbench of the 5x5 line median filter: directed table, random lines, predictor and checker.
module tb_median_filter_5x5_line_core
	import mf5_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Register index that decodes to nothing.
	localparam int REG_SPARE = 1;
	// Idle clock edges waited after the last expected pixel, so that the pipeline drains.
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		pix_t top2;
		pix_t top1;
		pix_t center;
		pix_t bot1;
		pix_t bot2;
	} col_t;

	typedef struct packed {
		pix_t pix;
		logic last;
	} pix_res_t;

	typedef enum logic [1:0] {
		OP_COLUMN      = 2'd0,
		OP_WRITE       = 2'd1,
		OP_WRITE_SPARE = 2'd2,
		OP_READ        = 2'd3
	} dir_op_t;

	// One row of the directed table. For reads, wval is the expected value.
	typedef struct packed {
		dir_op_t         op;
		logic [LW_W-1:0] wval;
		col_t            col;
		logic            known;
		pix_t            xpix;
	} dir_row_t;

	typedef enum logic [1:0] {
		PACE_RX_SLOW = 2'd0,
		PACE_TX_SLOW = 2'd1,
		PACE_FULL    = 2'd2
	} pace_t;

	typedef struct packed {
		logic [LW_W-1:0] width;
		logic [12:0]     ncols;
		pace_t           pace;
	} line_phase_t;

	localparam int DIR_N = 26;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{OP_READ,        13'd640,  40'h0,                                   1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF},     1'b1, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'hFF, 8'h00, 8'h00},     1'b1, 8'hFF},
		'{OP_COLUMN,      13'd0,    {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA},     1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00},     1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b0, 8'h00},
		// Shrinking the width below the current count ends the line at once.
		'{OP_WRITE,       13'd5,    40'h0,                                   1'b0, 8'h00},
		'{OP_READ,        13'd5,    40'h0,                                   1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A},     1'b0, 8'h00},
		// A write to an unused index must leave line_width alone.
		'{OP_WRITE_SPARE, 13'h1FFF, 40'h0,                                   1'b0, 8'h00},
		'{OP_READ,        13'd5,    40'h0,                                   1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b1, 8'hFF},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b1, 8'hFF},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b1, 8'hFF},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b1, 8'hFF},
		'{OP_COLUMN,      13'd0,    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},     1'b1, 8'hFF},
		// Width zero acts as the minimum line of five columns.
		'{OP_WRITE,       13'd0,    40'h0,                                   1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b1, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b1, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b1, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b1, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},     1'b1, 8'h00},
		// The largest register value acts as the maximum width.
		'{OP_WRITE,       13'h1FFF, 40'h0,                                   1'b0, 8'h00},
		'{OP_READ,        13'h1FFF, 40'h0,                                   1'b0, 8'h00},
		'{OP_COLUMN,      13'd0,    {8'h7F, 8'h80, 8'h01, 8'hFE, 8'h3C},     1'b1, 8'h01}
	};

	localparam int PHASE_N = 10;
	localparam line_phase_t PHASES [PHASE_N] = '{
		'{13'd5,    13'd12,   PACE_RX_SLOW},
		'{13'd0,    13'd6,    PACE_RX_SLOW},
		'{13'd11,   13'd12,   PACE_RX_SLOW},
		'{13'd4,    13'd6,    PACE_TX_SLOW},
		'{13'd6,    13'd8,    PACE_TX_SLOW},
		'{13'd4097, 13'd6,    PACE_TX_SLOW},
		'{13'd3,    13'd6,    PACE_TX_SLOW},
		'{13'h1FFF, 13'd10,   PACE_FULL},
		'{13'd4096, 13'd6,    PACE_FULL},
		'{13'd7,    13'd10,   PACE_FULL}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	mf5_in_if  col_if ();
	mf5_out_if pix_if ();

	median_filter_5x5_line_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.col_in  (col_if),
		.pix_out (pix_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: window, column index and the written line width.
	pix_t            win_px [WIN_N][WIN_N];
	logic [CNT_W-1:0] col_idx;
	logic [LW_W-1:0] line_w_q;
	pix_res_t        pix_expect [$];
	int              errors;
	int              snd_idle_pct;
	int              rcv_idle_pct;

	// Clock of 10 ns.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		pix_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Median of the 25 window pixels: the value with rank MEDIAN_RANK.
	function automatic pix_t window_median();
		int   below;
		int   equal;
		pix_t cand;
		for (int i = 0; i < WIN_SIZE; i++) begin
			cand  = win_px[i / WIN_N][i % WIN_N];
			below = 0;
			equal = 0;
			for (int j = 0; j < WIN_SIZE; j++) begin
				if (win_px[j / WIN_N][j % WIN_N] < cand)
					below++;
				else if (win_px[j / WIN_N][j % WIN_N] == cand)
					equal++;
			end
			if (below <= MEDIAN_RANK && below + equal > MEDIAN_RANK)
				return cand;
		end
		return '0;
	endfunction

	// Pixel near a base value in one case of four, so that ties occur often.
	function automatic pix_t rand_pix(input pix_t base);
		if ($urandom_range(3) == 0)
			return base + pix_t'($urandom_range(2));
		return pix_t'($urandom_range(255));
	endfunction

	// Shift one accepted column into the window and queue the pixels it causes.
	task automatic predict_column(input col_t c, input bit fixed_ok, input pix_t fixed_pix);
		logic [LW_W-1:0] eff_w;
		pix_t            col_px [WIN_N];
		pix_res_t        res [OUT_N];
		pix_t            med;
		int              n;
		bit              at_end;
		col_px = '{c.top2, c.top1, c.center, c.bot1, c.bot2};
		for (int r = 0; r < WIN_N; r++) begin
			for (int k = 0; k < WIN_N - 1; k++)
				win_px[r][k] = win_px[r][k + 1];
			win_px[r][WIN_N - 1] = col_px[r];
		end
		eff_w = line_w_q;
		if (eff_w < MIN_WIDTH)
			eff_w = LW_W'(MIN_WIDTH);
		if (eff_w > MAX_WIDTH)
			eff_w = LW_W'(MAX_WIDTH);
		at_end = (int'(col_idx) + 1 >= int'(eff_w));
		n = 0;
		if (col_idx < 2) begin
			res[0] = '{win_px[2][WIN_N - 1], 1'b1};
			n = 1;
		end else if (col_idx >= 4) begin
			med = window_median();
			if (at_end) begin
				res[0] = '{med, 1'b0};
				res[1] = '{win_px[2][WIN_N - 2], 1'b0};
				res[2] = '{win_px[2][WIN_N - 1], 1'b1};
				n = 3;
			end else begin
				res[0] = '{med, 1'b1};
				n = 1;
			end
		end
		col_idx = at_end ? '0 : col_idx + 1'b1;
		for (int i = 0; i < n; i++) begin
			if (fixed_ok)
				res[i].pix = fixed_pix;
			pix_expect.push_back(res[i]);
		end
	endtask

	// Offer one column request, sometimes after a random gap, and predict it once taken.
	task automatic send_col(input col_t c, input bit fixed_ok, input pix_t fixed_pix);
		if ($urandom_range(99) < snd_idle_pct) begin
			col_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		col_if.valid       <= 1'b1;
		col_if.row_top2    <= c.top2;
		col_if.row_top1    <= c.top1;
		col_if.row_center  <= c.center;
		col_if.row_bottom1 <= c.bot1;
		col_if.row_bottom2 <= c.bot2;
		do @(posedge clk); while (!col_if.ready);
		predict_column(c, fixed_ok, fixed_pix);
	endtask

	// Stop sending, wait for every expected pixel, then let the pipeline drain.
	task automatic settle();
		col_if.valid <= 1'b0;
		do @(posedge clk); while (pix_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic apb_write(input int idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_LINE_WIDTH)
			line_w_q = val[LW_W-1:0];
	endtask

	// APB read of a register, compared with the expected value.
	task automatic apb_read_check(input int idx, input logic [APB_DW-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Compare every accepted output pixel with the oldest expectation.
	always @(posedge clk) begin
		pix_res_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (pix_expect.size() == 0) begin
				$display("%0t: unexpected pixel_out %0h run_last %0b", $time,
					pix_if.pixel_out, pix_if.run_last);
				errors++;
			end else begin
				want = pix_expect.pop_front();
				if (pix_if.pixel_out !== want.pix) begin
					$display("%0t: pixel_out expected %0h actual %0h", $time,
						want.pix, pix_if.pixel_out);
					errors++;
				end
				if (pix_if.run_last !== want.last) begin
					$display("%0t: run_last expected %0b actual %0b", $time,
						want.last, pix_if.run_last);
					errors++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random lines at three paces.
	initial begin
		dir_row_t    row;
		line_phase_t ph;
		pix_t        base;
		col_t        c;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		col_if.valid       = 1'b0;
		col_if.row_top2    = '0;
		col_if.row_top1    = '0;
		col_if.row_center  = '0;
		col_if.row_bottom1 = '0;
		col_if.row_bottom2 = '0;
		pix_if.ready       = 1'b0;
		errors             = 0;
		snd_idle_pct       = 27;
		rcv_idle_pct       = 64;
		col_idx            = '0;
		line_w_q           = LW_RESET;
		for (int r = 0; r < WIN_N; r++)
			for (int k = 0; k < WIN_N; k++)
				win_px[r][k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_TAB[i];
			case (row.op)
				OP_COLUMN: begin
					send_col(row.col, row.known, row.xpix);
				end
				OP_WRITE: begin
					settle();
					apb_write(REG_LINE_WIDTH, APB_DW'(row.wval));
				end
				OP_WRITE_SPARE: begin
					settle();
					apb_write(REG_SPARE, APB_DW'(row.wval));
				end
				default: begin
					settle();
					apb_read_check(REG_LINE_WIDTH, APB_DW'(row.wval));
				end
			endcase
		end

		for (int p = 0; p < PHASE_N; p++) begin
			ph = PHASES[p];
			settle();
			case (ph.pace)
				PACE_RX_SLOW: begin
					snd_idle_pct = 27;
					rcv_idle_pct = 64;
				end
				PACE_TX_SLOW: begin
					snd_idle_pct = 64;
					rcv_idle_pct = 27;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			apb_write(REG_LINE_WIDTH, APB_DW'(ph.width));
			for (int k = 0; k < int'(ph.ncols); k++) begin
				// Now and then hold off until every pending pixel has come out.
				if ((p == 0 && k == 10) || $urandom_range(49) == 0) begin
					col_if.valid <= 1'b0;
					do @(posedge clk); while (pix_expect.size() != 0);
				end
				base = pix_t'($urandom_range(255));
				c    = '{rand_pix(base), rand_pix(base), rand_pix(base),
					rand_pix(base), rand_pix(base)};
				send_col(c, 1'b0, 8'h00);
			end
		end

		settle();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(10_000_000);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/mf5_pkg.sv
rtl/core/mf5_in_if.sv
rtl/core/mf5_out_if.sv
rtl/core/median_filter_5x5_line_core.sv
sim/tb_median_filter_5x5_line_core.sv
